[sv/bb_pkg.sv]
// Shared types, defaults and the reciprocal table for the 3x3 box blur.
package bb_pkg;

  localparam int MaxWidthDef  = 2048;
  localparam int MaxHeightDef = 2048;
  localparam int CfgW         = 12;
  localparam int PixW         = 24;
  localparam int SumW         = 12;  // 9 * 255 fits
  localparam int NumW         = 13;  // 2*sum + count fits
  localparam int CntW         = 4;
  localparam int RcpW         = 20;
  localparam int RcpShift     = 20;

  localparam logic [CfgW-1:0] WidthRst  = 12'd2048;
  localparam logic [CfgW-1:0] HeightRst = 12'd2048;

  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [2:0][2:0][PixW-1:0] win_t;  // [row][col]: above..below, left..right

  typedef struct packed {
    logic sum_en;
    logic mul_en;
    logic row_lo;   // row above lies inside the frame
    logic row_hi;   // row below lies inside the frame
    logic col_lo;
    logic col_hi;
  } avg_ctl_t;

  // ceil(2^20 / (2*count)) for the neighbor counts that can occur
  function automatic logic [RcpW-1:0] recip(input logic [CntW-1:0] cnt);
    logic [RcpW-1:0] r;
    r = '0;
    unique case (cnt)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/bb_line_mem.sv]
// One line store: synchronous memory, one write and one registered read port.
module bb_line_mem #(
  parameter int Depth = bb_pkg::MaxWidthDef,
  parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  bb_pkg::pix_t   wdata_i,
  input  logic           re_i,
  input  logic [AW-1:0]  raddr_i,
  output bb_pkg::pix_t   rdata_o
);

  bb_pkg::pix_t mem [Depth];
  bb_pkg::pix_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bb_avg.sv]
// Window sum, neighbor count and rounded divide by reciprocal multiply.
module bb_avg (
  input  logic             clk_i,
  input  bb_pkg::avg_ctl_t ctl_i,
  input  bb_pkg::win_t     win_i,
  output logic [7:0]       red_o,
  output logic [7:0]       green_o,
  output logic [7:0]       blue_o
);

  localparam int ProdW = bb_pkg::NumW + bb_pkg::RcpW;

  logic [2:0][bb_pkg::SumW-1:0] sum;
  logic [bb_pkg::CntW-1:0]      cnt;
  logic [1:0]                   nrow, ncol;
  logic [2:0][bb_pkg::NumW-1:0] num_q;
  logic [bb_pkg::RcpW-1:0]      rcp_q;
  logic [2:0][ProdW-1:0]        prod_q;
  logic [2:0]                   use_r, use_c;

  always_comb begin
    use_r = {ctl_i.row_hi, 1'b1, ctl_i.row_lo};
    use_c = {ctl_i.col_hi, 1'b1, ctl_i.col_lo};
    nrow  = 2'd1 + {1'b0, ctl_i.row_lo} + {1'b0, ctl_i.row_hi};
    ncol  = 2'd1 + {1'b0, ctl_i.col_lo} + {1'b0, ctl_i.col_hi};
    cnt   = {2'b00, nrow} * {2'b00, ncol};
    sum   = '0;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        if (use_r[dr] && use_c[dc]) begin
          for (int ch = 0; ch < 3; ch++) begin
            sum[ch] = sum[ch] +
                      bb_pkg::SumW'(win_i[dr][dc][(2-ch)*8 +: 8]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.sum_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        num_q[ch] <= {sum[ch], 1'b0} + bb_pkg::NumW'(cnt);
      end
      rcp_q <= bb_pkg::recip(cnt);
    end
    if (ctl_i.mul_en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prod_q[ch] <= ProdW'(num_q[ch]) * ProdW'(rcp_q);
      end
    end
  end

  assign red_o   = prod_q[0][bb_pkg::RcpShift +: 8];
  assign green_o = prod_q[1][bb_pkg::RcpShift +: 8];
  assign blue_o  = prod_q[2][bb_pkg::RcpShift +: 8];

endmodule

[sv/box_blur_3x3_rgb.sv]
// Top level of the streaming 3x3 RGB box blur.
//
//  channel | direction | handshake              | beat
//  in      | sink      | in_valid_i / in_stall_o | cmd_i, in_red/green/blue_i
//  out     | source    | out_valid_o / out_stall_i | out_red/green/blue_o, frame_done_o
//  cfg     | APB slave | psel/penable/pready     | frame_width at 0, frame_height at 4
//
// One beat at a time: a beat with no result ends after the line store read; one with a
// result goes on through the sum stage, the reciprocal multiply and the output stage.
// No clearing pass after reset; reads of unwritten words are masked by the row bounds.
// A full output register that is stalled holds the result stage; input stays stalled.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bb_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = bb_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  in_red_i,
  input  logic [7:0]  in_green_i,
  input  logic [7:0]  in_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic        frame_done_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRd   = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StMul  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;

  logic [bb_pkg::CfgW-1:0] cfg_w_q, cfg_h_q;
  logic [WCW-1:0] w;
  logic [RW-1:0]  h;
  int unsigned    w_tmp, h_tmp;

  logic [AW-1:0] in_col_q, out_col_q, col_q;
  logic [RW-1:0] in_row_q, out_row_q;
  bb_pkg::pix_t  pixel_q, above, middle;
  bb_pkg::win_t  win_q;
  logic          skip_q, emit_q, done_q;
  logic          cfg_wr, accept, in_frame, noop, col_wrap;

  bb_pkg::avg_ctl_t ctl;
  logic [7:0] avg_r, avg_g, avg_b;
  logic       out_valid_q, out_done_q;
  logic [7:0] out_r_q, out_g_q, out_b_q;
  logic       load_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == bb_pkg::RegHeight) ? {20'd0, cfg_h_q} : {20'd0, cfg_w_q};

  always_comb begin
    w_tmp = 32'(cfg_w_q);
    h_tmp = 32'(cfg_h_q);
    if (w_tmp == 0) w_tmp = 1;
    else if (w_tmp > MAX_WIDTH) w_tmp = MAX_WIDTH;
    if (h_tmp == 0) h_tmp = 1;
    else if (h_tmp > MAX_HEIGHT) h_tmp = MAX_HEIGHT;
    w = WCW'(w_tmp);
    h = RW'(h_tmp);
  end

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_frame   = in_row_q < h;
  assign noop       = cmd_i && in_frame;
  assign col_wrap   = (WCW'(in_col_q) + WCW'(1)) >= w;
  assign load_out   = (state_q == StOut) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = StRd;
      StRd:    state_d = emit_q ? StSum : StIdle;
      StSum:   state_d = StMul;
      StMul:   state_d = StOut;
      StOut:   if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl.sum_en = (state_q == StSum);
    ctl.mul_en = (state_q == StMul);
    ctl.row_lo = (out_row_q != '0);
    ctl.row_hi = (out_row_q + RW'(1)) < h;
    ctl.col_lo = (out_col_q != '0);
    ctl.col_hi = (WCW'(out_col_q) + WCW'(1)) < w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cfg_w_q     <= bb_pkg::WidthRst;
      cfg_h_q     <= bb_pkg::HeightRst;
      in_col_q    <= '0;
      in_row_q    <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      skip_q      <= 1'b0;
      emit_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      win_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        if (paddr[2] == bb_pkg::RegHeight) cfg_h_q <= pwdata[bb_pkg::CfgW-1:0];
        else cfg_w_q <= pwdata[bb_pkg::CfgW-1:0];
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (accept) begin
        skip_q <= noop;
        emit_q <= !noop && !((in_row_q == '0) ||
                             ((in_row_q == RW'(1)) && (in_col_q == '0)));
        if (!noop) begin
          if (col_wrap) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + RW'(1);
          end else begin
            in_col_q <= in_col_q + AW'(1);
          end
        end
      end else if (state_q == StSum) begin
        done_q <= !ctl.row_hi && !ctl.col_hi;
        if (!ctl.row_hi && !ctl.col_hi) begin
          // last pixel of the frame: restart all positions
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else if (!ctl.col_hi) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + RW'(1);
        end else begin
          out_col_q <= out_col_q + AW'(1);
        end
      end
      if (state_q == StRd && !skip_q) begin
        for (int dr = 0; dr < 3; dr++) begin
          win_q[dr][0] <= win_q[dr][1];
          win_q[dr][1] <= win_q[dr][2];
        end
        win_q[0][2] <= above;
        win_q[1][2] <= middle;
        win_q[2][2] <= pixel_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q   <= in_col_q;
      pixel_q <= in_frame ? {in_red_i, in_green_i, in_blue_i} : '0;
    end
    if (load_out) begin
      out_r_q    <= avg_r;
      out_g_q    <= avg_g;
      out_b_q    <= avg_b;
      out_done_q <= done_q;
    end
  end

  bb_line_mem #(.Depth(MAX_WIDTH), .AW(AW)) u_above (
    .clk_i   (clk_i),
    .we_i    (state_q == StRd && !skip_q),
    .waddr_i (col_q),
    .wdata_i (middle),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (above)
  );

  bb_line_mem #(.Depth(MAX_WIDTH), .AW(AW)) u_middle (
    .clk_i   (clk_i),
    .we_i    (state_q == StRd && !skip_q),
    .waddr_i (col_q),
    .wdata_i (pixel_q),
    .re_i    (accept),
    .raddr_i (in_col_q),
    .rdata_o (middle)
  );

  bb_avg u_avg (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .win_i   (win_q),
    .red_o   (avg_r),
    .green_o (avg_g),
    .blue_o  (avg_b)
  );

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_r_q;
  assign out_green_o  = out_g_q;
  assign out_blue_o   = out_b_q;
  assign frame_done_o = out_done_q;

endmodule

[sv/bb_chk.sv]
// Port-level checker for the box blur, bound to the top level.
module bb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_red_o,
  input logic       frame_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_red_o) && $stable(frame_done_o))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while the first is at work");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a beat was taken");

endmodule

bind box_blur_3x3_rgb bb_chk u_bb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_red_o    (out_red_o),
  .frame_done_o (frame_done_o)
);
